// File: hw/rtl/wsc_pkg.sv
// Package with the field widths, constants and register map of the sensor calibration block.
`timescale 1ns / 1ps

package wsc_pkg;

   localparam int ADC_BITS = 12;
   localparam int VALUE_BITS = 12;
   localparam int COUNT_BITS = 12;
   localparam int EDGE_SUM_BITS = 25;
   localparam int MID_SUM_BITS = 24;
   localparam int TOTAL_BITS = 28;
   localparam int WEIGHT_BITS = 15;
   localparam int ROUND_BITS = 3;
   localparam int PROD_BITS = 27;
   localparam int REM_BITS = WEIGHT_BITS + 1;
   localparam int DIV_CNT_BITS = 5;

   localparam logic [WEIGHT_BITS-1:0] START_WEIGHT = WEIGHT_BITS'(50);
   localparam logic [COUNT_BITS-1:0] MIN_ROUND_SAMPLES = COUNT_BITS'(20);
   localparam logic [ROUND_BITS-1:0] MAX_ROUNDS = ROUND_BITS'(5);
   localparam logic [COUNT_BITS-1:0] MAX_SAMPLES_RESET = COUNT_BITS'(100);

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_MAX_SAMPLES = 2'd0;
   localparam logic [1:0] REG_INITIAL_EDGE = 2'd1;
   localparam logic [1:0] REG_INITIAL_MID = 2'd2;

   // Division jobs of the shared divider.
   typedef enum logic [1:0] {
      DIV_EDGE_AVG = 2'd0,
      DIV_MID_AVG  = 2'd1,
      DIV_EDGE_VAL = 2'd2,
      DIV_MID_VAL  = 2'd3
   } div_sel_type;

endpackage

// File: hw/rtl/weighted_sensor_calibration.sv
// Top level of the weighted sensor calibration block with its sequencer and shared units.
`timescale 1ns / 1ps

// Each input word carries one sample of the left, right and middle ADC channels and yields
// one result word with the current calibration values and round flags. A sample that is
// accumulated is offered as a result in the next cycle. The sample that closes a round
// runs a small sequencer over one shared 15x12 multiplier and one shared restoring divider
// that retires one quotient bit per cycle: a round that is not applied passes the seed
// states to its result, an applied round adds four 28-bit divisions with the average, add
// and value states between them. The input side is not ready from acceptance until the
// result word has been taken.
module weighted_sensor_calibration (
   input  logic        clock,
   input  logic        reset,
   // adc_left [11:0], adc_right [23:12], adc_mid [35:24], zero fill [39:36]
   input  logic [39:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // calib_edge [11:0], calib_mid [23:12], round_closed [24], round_applied [25],
   // rounds_done [28:26], zero fill [31:29]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SEED_E = 4'd1;
   localparam logic [3:0] ST_SEED_M = 4'd2;
   localparam logic [3:0] ST_SEED_W = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_AVG_E  = 4'd5;
   localparam logic [3:0] ST_ADD_E  = 4'd6;
   localparam logic [3:0] ST_AVG_M  = 4'd7;
   localparam logic [3:0] ST_ADD_M  = 4'd8;
   localparam logic [3:0] ST_VAL_E  = 4'd9;
   localparam logic [3:0] ST_VAL_M  = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   localparam int AB = wsc_pkg::ADC_BITS;
   localparam int VB = wsc_pkg::VALUE_BITS;
   localparam int CB = wsc_pkg::COUNT_BITS;
   localparam int ESB = wsc_pkg::EDGE_SUM_BITS;
   localparam int MSB = wsc_pkg::MID_SUM_BITS;
   localparam int TB = wsc_pkg::TOTAL_BITS;
   localparam int WB = wsc_pkg::WEIGHT_BITS;
   localparam int RB = wsc_pkg::ROUND_BITS;
   localparam int PB = wsc_pkg::PROD_BITS;
   localparam int REMB = wsc_pkg::REM_BITS;
   localparam int DCB = wsc_pkg::DIV_CNT_BITS;

   logic [3:0]  state_ff, state_in;
   logic [CB-1:0] max_samples_ff, max_samples_in;
   logic [VB-1:0] initial_edge_ff, initial_edge_in;
   logic [VB-1:0] initial_mid_ff, initial_mid_in;
   logic [CB-1:0] sample_count_ff, sample_count_in;
   logic [ESB-1:0] edge_sum_ff, edge_sum_in;
   logic [MSB-1:0] mid_sum_ff, mid_sum_in;
   logic [RB-1:0] round_count_ff, round_count_in;
   logic [TB-1:0] edge_total_ff, edge_total_in;
   logic [TB-1:0] mid_total_ff, mid_total_in;
   logic [WB-1:0] total_weight_ff, total_weight_in;
   logic [VB-1:0] edge_value_ff, edge_value_in;
   logic [VB-1:0] mid_value_ff, mid_value_in;
   logic        closed_ff, closed_in;
   logic        applied_ff, applied_in;
   logic        seed_ff, seed_in;
   logic [PB-1:0] prod_ff, prod_in;
   logic [TB-1:0] quo_ff, quo_in;
   logic [REMB-1:0] rem_ff, rem_in;
   logic [WB-1:0] divisor_ff, divisor_in;
   logic [DCB-1:0] div_cnt_ff, div_cnt_in;
   wsc_pkg::div_sel_type div_sel_ff, div_sel_in;

   logic [AB-1:0] adc_left, adc_right, adc_mid;
   logic        req_fire, csr_write;
   logic [1:0]  csr_index;
   logic [WB-1:0] mul_a;
   logic [CB-1:0] mul_b;
   logic [REMB-1:0] rem_shift, rem_diff;
   logic        rem_ge;
   logic [WB-1:0] weight_sum;
   logic [WB-1:0] count_wide;

   assign adc_left = req_tdata[AB-1:0];
   assign adc_right = req_tdata[2*AB-1:AB];
   assign adc_mid = req_tdata[3*AB-1:2*AB];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {3'b000, round_count_ff, applied_ff, closed_ff, mid_value_ff,
                       edge_value_ff};

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[3:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         wsc_pkg::REG_MAX_SAMPLES:  csr_prdata = {20'd0, max_samples_ff};
         wsc_pkg::REG_INITIAL_EDGE: csr_prdata = {20'd0, initial_edge_ff};
         wsc_pkg::REG_INITIAL_MID:  csr_prdata = {20'd0, initial_mid_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign count_wide = {{(WB-CB){1'b0}}, sample_count_ff};
   assign weight_sum = total_weight_ff + count_wide;

   // One restoring division step: shift in the next dividend bit and try the subtract.
   assign rem_shift = {rem_ff[REMB-2:0], quo_ff[TB-1]};
   assign rem_diff = rem_shift - {1'b0, divisor_ff};
   assign rem_ge = (rem_shift >= {1'b0, divisor_ff});

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_SEED_E: begin
            mul_a = total_weight_ff;
            mul_b = edge_value_ff;
         end
         ST_SEED_M: begin
            mul_a = total_weight_ff;
            mul_b = mid_value_ff;
         end
         ST_AVG_E: begin
            mul_a = count_wide;
            mul_b = quo_ff[VB:1];
         end
         default: begin
            mul_a = count_wide;
            mul_b = quo_ff[VB-1:0];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      max_samples_in = max_samples_ff;
      initial_edge_in = initial_edge_ff;
      initial_mid_in = initial_mid_ff;
      sample_count_in = sample_count_ff;
      edge_sum_in = edge_sum_ff;
      mid_sum_in = mid_sum_ff;
      round_count_in = round_count_ff;
      edge_total_in = edge_total_ff;
      mid_total_in = mid_total_ff;
      total_weight_in = total_weight_ff;
      edge_value_in = edge_value_ff;
      mid_value_in = mid_value_ff;
      closed_in = closed_ff;
      applied_in = applied_ff;
      seed_in = seed_ff;
      prod_in = prod_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      div_cnt_in = div_cnt_ff;
      div_sel_in = div_sel_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (sample_count_ff < max_samples_ff) begin
                  sample_count_in = sample_count_ff + CB'(1);
                  edge_sum_in = edge_sum_ff + ESB'(adc_left) + ESB'(adc_right);
                  mid_sum_in = mid_sum_ff + MSB'(adc_mid);
                  closed_in = 1'b0;
                  applied_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  closed_in = 1'b1;
                  seed_in = (edge_total_ff == '0) && (mid_total_ff == '0);
                  applied_in = (sample_count_ff > wsc_pkg::MIN_ROUND_SAMPLES) &&
                               (round_count_ff < wsc_pkg::MAX_ROUNDS);
                  state_in = ST_SEED_E;
               end
            end
         end
         ST_SEED_E: begin
            prod_in = PB'(mul_a * mul_b);
            state_in = ST_SEED_M;
         end
         ST_SEED_M: begin
            if (seed_ff) begin
               edge_total_in = TB'(prod_ff);
            end
            prod_in = PB'(mul_a * mul_b);
            state_in = ST_SEED_W;
         end
         ST_SEED_W: begin
            if (seed_ff) begin
               mid_total_in = TB'(prod_ff);
            end
            if (applied_ff) begin
               quo_in = TB'(edge_sum_ff);
               rem_in = '0;
               divisor_in = count_wide;
               div_cnt_in = DCB'(TB - 1);
               div_sel_in = wsc_pkg::DIV_EDGE_AVG;
               state_in = ST_DIV;
            end else begin
               sample_count_in = '0;
               edge_sum_in = '0;
               mid_sum_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff : rem_shift;
            quo_in = {quo_ff[TB-2:0], rem_ge};
            div_cnt_in = div_cnt_ff - DCB'(1);
            if (div_cnt_ff == '0) begin
               unique case (div_sel_ff)
                  wsc_pkg::DIV_EDGE_AVG: state_in = ST_AVG_E;
                  wsc_pkg::DIV_MID_AVG:  state_in = ST_AVG_M;
                  wsc_pkg::DIV_EDGE_VAL: state_in = ST_VAL_E;
                  default:               state_in = ST_VAL_M;
               endcase
            end
         end
         ST_AVG_E: begin
            // The edge average is the quotient halved, so its bits start at bit one.
            prod_in = PB'(mul_a * mul_b);
            state_in = ST_ADD_E;
         end
         ST_ADD_E: begin
            edge_total_in = edge_total_ff + TB'(prod_ff);
            quo_in = TB'(mid_sum_ff);
            rem_in = '0;
            divisor_in = count_wide;
            div_cnt_in = DCB'(TB - 1);
            div_sel_in = wsc_pkg::DIV_MID_AVG;
            state_in = ST_DIV;
         end
         ST_AVG_M: begin
            prod_in = PB'(mul_a * mul_b);
            state_in = ST_ADD_M;
         end
         ST_ADD_M: begin
            mid_total_in = mid_total_ff + TB'(prod_ff);
            total_weight_in = weight_sum;
            round_count_in = round_count_ff + RB'(1);
            quo_in = edge_total_ff;
            rem_in = '0;
            divisor_in = weight_sum;
            div_cnt_in = DCB'(TB - 1);
            div_sel_in = wsc_pkg::DIV_EDGE_VAL;
            state_in = ST_DIV;
         end
         ST_VAL_E: begin
            edge_value_in = quo_ff[VB-1:0];
            quo_in = mid_total_ff;
            rem_in = '0;
            div_cnt_in = DCB'(TB - 1);
            div_sel_in = wsc_pkg::DIV_MID_VAL;
            state_in = ST_DIV;
         end
         ST_VAL_M: begin
            mid_value_in = quo_ff[VB-1:0];
            sample_count_in = '0;
            edge_sum_in = '0;
            mid_sum_in = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must issue configuration writes only while the block is idle; the block does not enforce it.
      if (csr_write) begin
         unique case (csr_index)
            wsc_pkg::REG_MAX_SAMPLES: begin
               max_samples_in = csr_pwdata[CB-1:0];
            end
            wsc_pkg::REG_INITIAL_EDGE: begin
               initial_edge_in = csr_pwdata[VB-1:0];
               edge_value_in = csr_pwdata[VB-1:0];
            end
            wsc_pkg::REG_INITIAL_MID: begin
               initial_mid_in = csr_pwdata[VB-1:0];
               mid_value_in = csr_pwdata[VB-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_samples_ff <= wsc_pkg::MAX_SAMPLES_RESET;
         initial_edge_ff <= '0;
         initial_mid_ff <= '0;
         sample_count_ff <= '0;
         edge_sum_ff <= '0;
         mid_sum_ff <= '0;
         round_count_ff <= '0;
         edge_total_ff <= '0;
         mid_total_ff <= '0;
         total_weight_ff <= wsc_pkg::START_WEIGHT;
         edge_value_ff <= '0;
         mid_value_ff <= '0;
         closed_ff <= 1'b0;
         applied_ff <= 1'b0;
         seed_ff <= 1'b0;
         div_cnt_ff <= '0;
         div_sel_ff <= wsc_pkg::DIV_EDGE_AVG;
      end else begin
         state_ff <= state_in;
         max_samples_ff <= max_samples_in;
         initial_edge_ff <= initial_edge_in;
         initial_mid_ff <= initial_mid_in;
         sample_count_ff <= sample_count_in;
         edge_sum_ff <= edge_sum_in;
         mid_sum_ff <= mid_sum_in;
         round_count_ff <= round_count_in;
         edge_total_ff <= edge_total_in;
         mid_total_ff <= mid_total_in;
         total_weight_ff <= total_weight_in;
         edge_value_ff <= edge_value_in;
         mid_value_ff <= mid_value_in;
         closed_ff <= closed_in;
         applied_ff <= applied_in;
         seed_ff <= seed_in;
         div_cnt_ff <= div_cnt_in;
         div_sel_ff <= div_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule
